[rtl/pmbc_pkg.sv]
// Package for the per-address byte count table: payload types, counter record,
// address class codes and the reserved-prefix classifier.
// No dependencies.
package pmbc_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;

  localparam int MAC_W     = 48;
  localparam int LEN_W     = 16;
  localparam int IDX_IN_W  = 6;
  localparam int SLOT_W    = 6;
  localparam int USED_W    = 7;
  localparam int TOT_W     = 48;
  localparam int WIN_W     = 32;
  localparam int CLASS_W   = 3;

  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [CLASS_W-1:0] CLS_ORDINARY = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_IPV4_MC  = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_IPV6_MC  = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_PPP      = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_BCAST    = 3'd4;

  localparam logic [23:0] OUI_IPV4_MC    = 24'h01005E;
  localparam logic [23:0] OUI_IPV6_MC_LO = 24'h333300;
  localparam logic [23:0] OUI_IPV6_MC_HI = 24'h3333FF;
  localparam logic [23:0] OUI_PPP_LO     = 24'hCF0000;
  localparam logic [23:0] OUI_PPP_HI     = 24'hCFFFFF;
  localparam logic [23:0] OUI_BCAST      = 24'hFFFFFF;

  typedef struct packed {
    logic                opcode;
    logic [MAC_W-1:0]    src_mac;
    logic [MAC_W-1:0]    dst_mac;
    logic [LEN_W-1:0]    frame_length;
    logic [IDX_IN_W-1:0] entry_index;
  } in_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  src_slot;
    logic [SLOT_W-1:0]  dst_slot;
    logic               src_dropped;
    logic               dst_dropped;
    logic               entry_valid;
    logic [MAC_W-1:0]   entry_mac;
    logic [CLASS_W-1:0] address_class;
    logic [TOT_W-1:0]   sent_total_out;
    logic [TOT_W-1:0]   recv_total_out;
    logic [WIN_W-1:0]   sent_window_out;
    logic [WIN_W-1:0]   recv_window_out;
    logic [USED_W-1:0]  entries_used;
  } out_res_t;

  // One counter memory word per entry
  typedef struct packed {
    logic [TOT_W-1:0] sent_total;
    logic [TOT_W-1:0] recv_total;
    logic [WIN_W-1:0] sent_win;
    logic [WIN_W-1:0] recv_win;
  } cnt_rec_t;

  typedef struct packed {
    logic is_new;     // entry just appended: old word is garbage, count from zero
    logic to_recv;    // add to the received pair instead of the sent pair
    logic clear_win;  // read request: zero both windows, add nothing
  } upd_ctl_t;

  function automatic logic [CLASS_W-1:0] classify(input logic [MAC_W-1:0] mac);
    logic [23:0]        oui;
    logic [CLASS_W-1:0] cls;
    oui = mac[47:24];
    priority if (oui == OUI_IPV4_MC) begin
      cls = CLS_IPV4_MC;
    end else if (oui >= OUI_IPV6_MC_LO && oui <= OUI_IPV6_MC_HI) begin
      cls = CLS_IPV6_MC;
    end else if (oui >= OUI_PPP_LO && oui <= OUI_PPP_HI) begin
      cls = CLS_PPP;
    end else if (oui == OUI_BCAST) begin
      cls = CLS_BCAST;
    end else begin
      cls = CLS_ORDINARY;
    end
    return cls;
  endfunction

endpackage

[rtl/pmbc_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pmbc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/pmbc_cnt_upd.sv]
// Saturating update of one counter word: add a frame length to the sent or
// received pair, or clear both windows. Uses pmbc_pkg.
module pmbc_cnt_upd (
  input  pmbc_pkg::cnt_rec_t              old_rec,
  input  pmbc_pkg::upd_ctl_t              ctl,
  input  logic [pmbc_pkg::LEN_W-1:0]      len,
  output pmbc_pkg::cnt_rec_t              new_rec
);

  pmbc_pkg::cnt_rec_t            base;
  logic [pmbc_pkg::TOT_W-1:0]    tot_in;
  logic [pmbc_pkg::WIN_W-1:0]    win_in;
  logic [pmbc_pkg::TOT_W:0]      tot_sum;
  logic [pmbc_pkg::WIN_W:0]      win_sum;
  logic [pmbc_pkg::TOT_W-1:0]    tot_sat;
  logic [pmbc_pkg::WIN_W-1:0]    win_sat;

  always_comb begin
    base    = ctl.is_new ? '0 : old_rec;
    tot_in  = ctl.to_recv ? base.recv_total : base.sent_total;
    win_in  = ctl.to_recv ? base.recv_win : base.sent_win;
    tot_sum = {1'b0, tot_in} + {{(pmbc_pkg::TOT_W + 1 - pmbc_pkg::LEN_W){1'b0}}, len};
    win_sum = {1'b0, win_in} + {{(pmbc_pkg::WIN_W + 1 - pmbc_pkg::LEN_W){1'b0}}, len};
    // clamp on carry out
    tot_sat = tot_sum[pmbc_pkg::TOT_W] ? '1 : tot_sum[pmbc_pkg::TOT_W-1:0];
    win_sat = win_sum[pmbc_pkg::WIN_W] ? '1 : win_sum[pmbc_pkg::WIN_W-1:0];

    new_rec = base;
    if (ctl.clear_win) begin
      new_rec.sent_win = '0;
      new_rec.recv_win = '0;
    end else if (ctl.to_recv) begin
      new_rec.recv_total = tot_sat;
      new_rec.recv_win   = win_sat;
    end else begin
      new_rec.sent_total = tot_sat;
      new_rec.sent_win   = win_sat;
    end
  end

endmodule

[rtl/per_mac_byte_count_table.sv]
// Per-address byte count table. Top level: sequencer, address search and
// counter read-modify-write. Uses pmbc_pkg, pmbc_ram and pmbc_cnt_upd.
//
// Usage:
//   Drive in_req and raise start while busy is low; the request is taken at
//   that edge and busy rises for the duration of the work. One result comes
//   back per request on out_res, marked by a one-cycle out_valid pulse. The
//   receiver cannot hold it off; out_valid is only ever high with busy low,
//   so the next request can be taken at the edge that ends the strobe.
//   Count request: each address is searched linearly through the address
//   RAM, one entry per cycle, appended when new while the table has room
//   (dropped when it is full), and its counters read in S_CRD and written
//   in S_CWR; source on the sent pair, then destination on the received
//   pair. The single read port of the address RAM sets the search rate.
//   Read request: the entry is read in S_RDA and returned from S_RDB, where
//   its windows are cleared; an index not below the entry count is answered
//   from S_RDA with no entry.
//   Reset: the entry count goes to zero; the RAMs are not cleared, since
//   only appended entries are searched or read and a new entry's old
//   counter word is ignored.
module per_mac_byte_count_table #(
  parameter int TABLE_ENTRIES = pmbc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pmbc_pkg::in_req_t  in_req,
  output logic               out_valid,
  output pmbc_pkg::out_res_t out_res
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CW    = $bits(pmbc_pkg::cnt_rec_t);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SEARCH = 7'b0000010,
    S_CRD    = 7'b0000100,
    S_CWR    = 7'b0001000,
    S_PDONE  = 7'b0010000,
    S_RDA    = 7'b0100000,
    S_RDB    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic             phase_dst_r, phase_dst_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic             is_new_r, is_new_nxt;
  logic [IDX_W-1:0] src_slot_r, src_slot_nxt;
  logic [IDX_W-1:0] dst_slot_r, dst_slot_nxt;
  logic             src_drop_r, src_drop_nxt;
  logic             dst_drop_r, dst_drop_nxt;
  logic             out_valid_r, out_valid_nxt;
  pmbc_pkg::in_req_t  req_r, req_nxt;
  pmbc_pkg::out_res_t out_res_r, out_res_nxt;

  // RAM ports
  logic                           a_we, a_re;
  logic [IDX_W-1:0]               a_waddr, a_raddr;
  logic [pmbc_pkg::MAC_W-1:0]     a_rdata;
  logic                           c_we, c_re;
  logic [IDX_W-1:0]               c_waddr, c_raddr;
  pmbc_pkg::cnt_rec_t             c_rdata, c_wdata;
  logic [CW-1:0]                  c_rdata_raw;

  pmbc_pkg::upd_ctl_t             upd_ctl;
  pmbc_pkg::cnt_rec_t             upd_rec;

  logic [pmbc_pkg::MAC_W-1:0]     cur_mac;
  logic                           hit;
  logic                           table_full;
  logic                           idx_ok;
  logic [IDX_W-1:0]               idx_addr;
  logic [IDX_W+pmbc_pkg::IDX_IN_W-1:0] idx_addr_ext;
  logic [IDX_W+pmbc_pkg::SLOT_W-1:0]   src_slot_ext, dst_slot_ext;
  logic [CNT_W+pmbc_pkg::USED_W-1:0]   used_ext;
  logic [pmbc_pkg::USED_W-1:0]         used;

  pmbc_ram #(.WIDTH(pmbc_pkg::MAC_W), .DEPTH(TABLE_ENTRIES)) u_addr_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (cur_mac),
    .re    (a_re),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  pmbc_ram #(.WIDTH(CW), .DEPTH(TABLE_ENTRIES)) u_cnt_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (c_re),
    .raddr (c_raddr),
    .rdata (c_rdata_raw)
  );

  assign c_rdata = pmbc_pkg::cnt_rec_t'(c_rdata_raw);

  pmbc_cnt_upd u_cnt_upd (
    .old_rec (c_rdata),
    .ctl     (upd_ctl),
    .len     (req_r.frame_length),
    .new_rec (upd_rec)
  );

  assign c_wdata = upd_rec;

  assign cur_mac    = phase_dst_r ? req_r.dst_mac : req_r.src_mac;
  assign hit        = pend_r && (a_rdata == cur_mac);
  assign table_full = (fill_r >= CNT_W'(TABLE_ENTRIES));
  assign idx_ok     = ({{CNT_W{1'b0}}, req_r.entry_index} <
                       {{pmbc_pkg::IDX_IN_W{1'b0}}, fill_r});
  assign idx_addr_ext = {{IDX_W{1'b0}}, req_r.entry_index};
  assign idx_addr     = idx_addr_ext[IDX_W-1:0];
  assign src_slot_ext = {{pmbc_pkg::SLOT_W{1'b0}}, src_slot_r};
  assign dst_slot_ext = {{pmbc_pkg::SLOT_W{1'b0}}, dst_slot_r};
  assign used_ext     = {{pmbc_pkg::USED_W{1'b0}}, fill_r};
  assign used         = used_ext[pmbc_pkg::USED_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    rd_idx_nxt    = rd_idx_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    phase_dst_nxt = phase_dst_r;
    slot_nxt      = slot_r;
    is_new_nxt    = is_new_r;
    src_slot_nxt  = src_slot_r;
    dst_slot_nxt  = dst_slot_r;
    src_drop_nxt  = src_drop_r;
    dst_drop_nxt  = dst_drop_r;
    req_nxt       = req_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = 1'b0;

    a_we    = 1'b0;
    a_waddr = slot_r;
    a_re    = 1'b0;
    a_raddr = rd_idx_r[IDX_W-1:0];
    c_we    = 1'b0;
    c_waddr = slot_r;
    c_re    = 1'b0;
    c_raddr = slot_r;
    upd_ctl.is_new    = is_new_r;
    upd_ctl.to_recv   = phase_dst_r;
    upd_ctl.clear_win = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt       = in_req;
          phase_dst_nxt = 1'b0;
          rd_idx_nxt    = '0;
          pend_nxt      = 1'b0;
          src_slot_nxt  = '0;
          dst_slot_nxt  = '0;
          src_drop_nxt  = 1'b0;
          dst_drop_nxt  = 1'b0;
          state_nxt     = (in_req.opcode == pmbc_pkg::OP_READ) ? S_RDA : S_SEARCH;
        end
      end

      S_SEARCH: begin
        if (hit) begin
          slot_nxt   = pend_idx_r;
          is_new_nxt = 1'b0;
          state_nxt  = S_CRD;
        end else if (!pend_r && rd_idx_r >= fill_r) begin
          if (!table_full) begin
            slot_nxt   = fill_r[IDX_W-1:0];
            is_new_nxt = 1'b1;
            state_nxt  = S_CRD;
          end else if (phase_dst_r) begin
            dst_drop_nxt = 1'b1;
            dst_slot_nxt = '0;
            state_nxt    = S_PDONE;
          end else begin
            // drop the source, go on with the destination
            src_drop_nxt  = 1'b1;
            src_slot_nxt  = '0;
            phase_dst_nxt = 1'b1;
            rd_idx_nxt    = '0;
            pend_nxt      = 1'b0;
          end
        end else if (rd_idx_r < fill_r) begin
          a_re         = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt   = rd_idx_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
      end

      S_CRD: begin
        c_re = 1'b1;
        if (is_new_r) begin
          a_we     = 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
        state_nxt = S_CWR;
      end

      S_CWR: begin
        c_we = 1'b1;
        if (phase_dst_r) begin
          dst_slot_nxt = slot_r;
          state_nxt    = S_PDONE;
        end else begin
          src_slot_nxt  = slot_r;
          phase_dst_nxt = 1'b1;
          rd_idx_nxt    = '0;
          pend_nxt      = 1'b0;
          state_nxt     = S_SEARCH;
        end
      end

      S_PDONE: begin
        out_res_nxt              = '0;
        out_res_nxt.src_slot     = src_slot_ext[pmbc_pkg::SLOT_W-1:0];
        out_res_nxt.dst_slot     = dst_slot_ext[pmbc_pkg::SLOT_W-1:0];
        out_res_nxt.src_dropped  = src_drop_r;
        out_res_nxt.dst_dropped  = dst_drop_r;
        out_res_nxt.entries_used = used;
        out_valid_nxt            = 1'b1;
        state_nxt                = S_IDLE;
      end

      S_RDA: begin
        a_raddr = idx_addr;
        c_raddr = idx_addr;
        if (idx_ok) begin
          a_re      = 1'b1;
          c_re      = 1'b1;
          state_nxt = S_RDB;
        end else begin
          out_res_nxt              = '0;
          out_res_nxt.entries_used = used;
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end

      S_RDB: begin
        // write back with both windows cleared
        upd_ctl.is_new    = 1'b0;
        upd_ctl.clear_win = 1'b1;
        c_we    = 1'b1;
        c_waddr = idx_addr;
        out_res_nxt                 = '0;
        out_res_nxt.entry_valid     = 1'b1;
        out_res_nxt.entry_mac       = a_rdata;
        out_res_nxt.address_class   = pmbc_pkg::classify(a_rdata);
        out_res_nxt.sent_total_out  = c_rdata.sent_total;
        out_res_nxt.recv_total_out  = c_rdata.recv_total;
        out_res_nxt.sent_window_out = c_rdata.sent_win;
        out_res_nxt.recv_window_out = c_rdata.recv_win;
        out_res_nxt.entries_used    = used;
        out_valid_nxt               = 1'b1;
        state_nxt                   = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      rd_idx_r    <= '0;
      pend_r      <= 1'b0;
      phase_dst_r <= 1'b0;
      is_new_r    <= 1'b0;
      src_drop_r  <= 1'b0;
      dst_drop_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rd_idx_r    <= rd_idx_nxt;
      pend_r      <= pend_nxt;
      phase_dst_r <= phase_dst_nxt;
      is_new_r    <= is_new_nxt;
      src_drop_r  <= src_drop_nxt;
      dst_drop_r  <= dst_drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    slot_r     <= slot_nxt;
    src_slot_r <= src_slot_nxt;
    dst_slot_r <= dst_slot_nxt;
    req_r      <= req_nxt;
    out_res_r  <= out_res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTH
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count beyond table depth");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != $past(fill_r)) |-> (fill_r == CNT_W'($past(fill_r) + 1'b1)))
    else $error("entry count moved by other than one");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");
`endif

endmodule
